/* rtl/core/mlrq_pkg.sv */
package mlrq_pkg;

  localparam logic [1:0] KIND_ENQ = 2'd0;
  localparam logic [1:0] KIND_REM = 2'd1;

  localparam logic [2:0] ST_ENQUEUED  = 3'd0;
  localparam logic [2:0] ST_REMOVED   = 3'd1;
  localparam logic [2:0] ST_BAD_LEVEL = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_QUERY     = 3'd5;

  typedef enum logic [10:0] {
    S_INIT   = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_ENQ    = 11'b00000000100,
    S_SCAN   = 11'b00000001000,
    S_LOOK   = 11'b00000010000,
    S_UNLINK = 11'b00000100000,
    S_FIX    = 11'b00001000000,
    S_HEAD   = 11'b00010000000,
    S_HWAIT  = 11'b00100000000,
    S_OUT    = 11'b01000000000,
    S_FREE   = 11'b10000000000
  } state_t;

endpackage

/* rtl/core/mlrq_ram.sv */
module mlrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/multilevel_ready_queue.sv */
// Four-level ready queue (LEVELS configurable) holding task identifiers in a shared
// store of SLOTS linked slots. Each input word (kind, task_id, level) gives one result
// word (status, next_task, next_is_idle, next_level). After reset the free-slot stack
// is loaded by a pass over all SLOTS slots before the first word is taken. A remove
// walks the levels from head to tail through the slot memory. Words are handled one
// at a time; the result stays in an output register until taken, and a result not
// yet taken holds the next one back.
module multilevel_ready_queue import mlrq_pkg::*; #(
  parameter int LEVELS       = 4,
  parameter int SLOTS        = 64,
  parameter int TASK_ID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // kind[1:0], task_id[9:2], level[12:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status[2:0], next_task[10:3], next_is_idle[11],
                                  // next_level[13:12]
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int SB = $clog2(SLOTS);
  localparam int LB = $clog2(LEVELS);
  localparam int CB = SB + 1;

  state_t state_r, state_nxt;

  logic [7:0]    idle_r;
  logic [1:0]    kind_r;
  logic [7:0]    id_r;
  logic [2:0]    lvl_r;
  logic [2:0]    status_r;
  logic [SB-1:0] head_r [LEVELS];
  logic [SB-1:0] tail_r [LEVELS];
  logic [CB-1:0] cnt_r  [LEVELS];
  logic [CB-1:0] free_cnt_r;
  logic [LB-1:0] lv_r;
  logic [CB-1:0] idx_r;
  logic [SB-1:0] cur_r;
  logic [SB-1:0] slot_r;
  logic          out_valid_r;
  logic [15:0]   out_data_r;

  // memories
  logic          t_we, n_we, p_we, f_we;
  logic [SB-1:0] t_wa, n_wa, p_wa, f_wa, t_ra, n_ra, p_ra, f_ra;
  logic [7:0]    t_wd, t_rd;
  logic [SB-1:0] n_wd, n_rd, p_wd, p_rd, f_wd, f_rd;

  mlrq_ram #(.WIDTH(8),  .DEPTH(SLOTS)) u_task (.clk, .we(t_we), .waddr(t_wa), .wdata(t_wd),
                                                .raddr(t_ra), .rdata(t_rd));
  mlrq_ram #(.WIDTH(SB), .DEPTH(SLOTS)) u_next (.clk, .we(n_we), .waddr(n_wa), .wdata(n_wd),
                                                .raddr(n_ra), .rdata(n_rd));
  mlrq_ram #(.WIDTH(SB), .DEPTH(SLOTS)) u_prev (.clk, .we(p_we), .waddr(p_wa), .wdata(p_wd),
                                                .raddr(p_ra), .rdata(p_rd));
  mlrq_ram #(.WIDTH(SB), .DEPTH(SLOTS)) u_free (.clk, .we(f_we), .waddr(f_wa), .wdata(f_wd),
                                                .raddr(f_ra), .rdata(f_rd));

  logic [7:0]    id_in;
  logic [7:0]    tmask;
  logic          any_ne;
  logic [LB-1:0] first_lv;
  logic [LB-1:0] elv;
  logic          is_h, is_t;
  logic [SB-1:0] h_lv, t_lv;

  assign tmask = 8'((9'd1 << TASK_ID_BITS) - 9'd1);
  assign id_in = in_tdata[9:2] & tmask;
  assign elv   = LB'(lvl_r);
  assign h_lv  = head_r[lv_r];
  assign t_lv  = tail_r[lv_r];
  assign is_h  = (slot_r == h_lv);
  assign is_t  = (slot_r == t_lv);

  always_comb begin
    any_ne = 1'b0;
    first_lv = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt_r[l] != '0) begin
        any_ne = 1'b1;
        first_lv = LB'(l);
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    t_we = 1'b0; t_wa = slot_r; t_wd = id_r; t_ra = cur_r;
    n_we = 1'b0; n_wa = slot_r; n_wd = '0;   n_ra = cur_r;
    p_we = 1'b0; p_wa = slot_r; p_wd = '0;   p_ra = slot_r;
    f_we = 1'b0; f_wa = idx_r[SB-1:0]; f_wd = SB'(SLOTS - 1) - idx_r[SB-1:0];
    f_ra = SB'(free_cnt_r - CB'(1));
    case (state_r)
      S_INIT: begin
        f_we = 1'b1;
        if (idx_r == CB'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tdata[1:0] == KIND_ENQ) begin
            state_nxt = (int'(in_tdata[12:10]) < LEVELS && free_cnt_r != '0) ? S_ENQ : S_HEAD;
          end else if (in_tdata[1:0] == KIND_REM) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_HEAD;
          end
        end
      end
      S_ENQ: begin
        t_we = 1'b1; t_wa = f_rd; t_wd = id_r;
        n_we = 1'b1; n_wa = f_rd; n_wd = '0;
        p_we = 1'b1; p_wa = f_rd; p_wd = (cnt_r[elv] == '0) ? '0 : tail_r[elv];
        state_nxt = S_FIX;
      end
      S_FIX: begin
        n_we = (kind_r == KIND_ENQ) ? (cnt_r[elv] != CB'(1)) : (!is_h && !is_t);
        n_wa = (kind_r == KIND_ENQ) ? tail_r[elv] : cur_r;
        n_wd = (kind_r == KIND_ENQ) ? slot_r : n_rd;
        state_nxt = S_HEAD;
      end
      S_SCAN: begin
        if (idx_r < cnt_r[lv_r]) begin
          state_nxt = S_LOOK;
        end else if (lv_r == LB'(LEVELS - 1)) begin
          state_nxt = S_HEAD;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_LOOK: begin
        state_nxt = (t_rd == id_r) ? S_UNLINK : S_SCAN;
      end
      S_UNLINK: begin
        // slot_r holds the slot; n_rd/p_rd now valid
        f_we = 1'b1; f_wa = free_cnt_r[SB-1:0]; f_wd = slot_r;
        if (!is_h && is_t) begin
          n_we = 1'b1; n_wa = p_rd; n_wd = '0;
        end
        if (!is_h && !is_t) begin
          p_we = 1'b1; p_wa = n_rd; p_wd = p_rd;
          n_we = 1'b1; n_wa = p_rd; n_wd = n_rd;
        end
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        t_ra = head_r[first_lv];
        state_nxt = S_HWAIT;
      end
      S_HWAIT: begin
        t_ra = head_r[first_lv];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        t_ra = head_r[first_lv];
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idle_r      <= '0;
      free_cnt_r  <= CB'(SLOTS);
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        idle_r <= cfg_wdata;
      end
      if (out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: idx_r <= idx_r + CB'(1);
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r <= in_tdata[1:0];
            id_r   <= id_in;
            lvl_r  <= in_tdata[12:10];
            lv_r   <= '0;
            idx_r  <= '0;
            cur_r  <= head_r[0];
            if (in_tdata[1:0] == KIND_ENQ) begin
              status_r <= (int'(in_tdata[12:10]) >= LEVELS) ? ST_BAD_LEVEL :
                          (free_cnt_r == '0) ? ST_FULL : ST_ENQUEUED;
            end else if (in_tdata[1:0] == KIND_REM) begin
              status_r <= ST_NOT_FOUND;
            end else begin
              status_r <= ST_QUERY;
            end
          end
        end
        S_ENQ: begin
          slot_r     <= f_rd;
          free_cnt_r <= free_cnt_r - CB'(1);
          if (cnt_r[elv] == '0) begin
            head_r[elv] <= f_rd;
          end
          cnt_r[elv]  <= cnt_r[elv] + CB'(1);
        end
        S_FIX: begin
          if (kind_r == KIND_ENQ) begin
            tail_r[elv] <= slot_r;
          end
        end
        S_SCAN: begin
          if (!(idx_r < cnt_r[lv_r])) begin
            lv_r  <= lv_r + LB'(1);
            idx_r <= '0;
            cur_r <= head_r[LB'(lv_r + LB'(1))];
          end else begin
            slot_r <= cur_r;
          end
        end
        S_LOOK: begin
          if (t_rd != id_r) begin
            cur_r <= n_rd;
            idx_r <= idx_r + CB'(1);
          end
        end
        S_UNLINK: begin
          status_r   <= ST_REMOVED;
          free_cnt_r <= free_cnt_r + CB'(1);
          cnt_r[lv_r] <= cnt_r[lv_r] - CB'(1);
          if (is_h && is_t) begin
            head_r[lv_r] <= '0;
            tail_r[lv_r] <= '0;
          end else if (is_h) begin
            head_r[lv_r] <= n_rd;
          end else if (is_t) begin
            tail_r[lv_r] <= p_rd;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {2'b00, any_ne ? 2'(first_lv) : 2'd0, !any_ne,
                            any_ne ? t_rd : idle_r, status_r};
          end
        end
        default: ;
      endcase
    end
  end

endmodule
